>>> hdl/calf_pkg.sv
// shared types, codes and arithmetic helpers for the cascaded all-pole lpc filter
// no dependencies; imported by calf_mac, calf_ctrl and the top level
`timescale 1ns / 1ps

package calf_pkg;

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_COEF   = 2'd1,
        OP_BLEND  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_RUN,
        ST_F_DRAIN1,
        ST_F_DRAIN2,
        ST_F_FIN,
        ST_F_OUT,
        ST_B_KEEP,
        ST_B_GIVE,
        ST_B_WAIT1,
        ST_B_WAIT2,
        ST_B_WB
    } t_state;

    // operand source for the shared multiplier
    typedef enum logic [1:0] {
        SRC_HIST,
        SRC_KEEP,
        SRC_GIVE
    } t_src;

    // history ram write data select
    typedef enum logic [1:0] {
        HW_ZERO,
        HW_SHIFT,
        HW_Y
    } t_hw_sel;

    typedef struct packed {
        logic mul_en;
        logic sub;
        t_src src;
    } t_mul_ctl;

    typedef struct packed {
        logic load;
        logic blend;
    } t_acc_ctl;

    typedef struct packed {
        logic    en;
        t_hw_sel sel;
    } t_hw_ctl;

    localparam logic [15:0]        DECAY_RESET = 16'd39322;
    localparam logic [16:0]        ONE_Q16     = 17'h10000;
    localparam logic signed [63:0] ROUND_HALF  = 64'sd32768;

    function automatic logic [16:0] blend_give(input logic [15:0] keep);
        return ONE_Q16 - {1'b0, keep};
    endfunction

    // round half up at bit 16, then clamp to the signed 32-bit range
    function automatic logic signed [31:0] round_sat32(input logic signed [63:0] acc);
        logic signed [63:0] v;
        logic        [47:0] q;
        logic signed [31:0] res;
        v = acc + ROUND_HALF;
        q = v[63:16];
        if ((&q[47:31]) || !(|q[47:31])) begin
            res = q[31:0];
        end else if (q[47]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

>>> hdl/calf_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module calf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/calf_mac.sv
// shared multiply-accumulate unit: registered 24x32 signed product into a 64-bit accumulator
// depends on calf_pkg
`timescale 1ns / 1ps

module calf_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  calf_pkg::t_mul_ctl  i_mul,
    input  logic signed [23:0]  i_a,
    input  logic signed [31:0]  i_b,
    input  calf_pkg::t_acc_ctl  i_acc,
    input  logic signed [31:0]  i_x,
    output logic signed [63:0]  o_acc
);

    import calf_pkg::*;

    logic signed [55:0] r_prod;
    logic               r_prod_vld;
    logic               r_prod_sub;
    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic signed [63:0] prod_ext;
    logic signed [63:0] init;

    assign prod_ext = {{8{r_prod[55]}}, r_prod};
    assign init     = i_acc.blend ? ROUND_HALF : {{16{i_x[31]}}, i_x, 16'h0000};

    always_comb begin
        n_acc = r_acc;
        if (i_acc.load) begin
            n_acc = init;
        end else if (r_prod_vld) begin
            n_acc = r_prod_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_mul.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= i_a * i_b;
        r_prod_sub <= i_mul.sub;
        r_acc      <= n_acc;
    end

    assign o_acc = r_acc;

    // a reload must never drop a product that is still on its way
    a_load_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc.load |-> !r_prod_vld)
        else $error("accumulator reloaded with a product pending");

endmodule

>>> hdl/calf_ctrl.sv
// sequencer: clearing sweep, per-pass tap loop and coefficient blend loop
// depends on calf_pkg; drives the history ram and the shared mac
`timescale 1ns / 1ps

module calf_ctrl #(
    parameter int ORDER   = 16,
    parameter int PASSES  = 2,
    localparam int DEPTH  = PASSES * ORDER,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int KW     = (ORDER > 1) ? $clog2(ORDER) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  calf_pkg::t_op      i_op,
    input  logic               i_out_free,
    output logic               o_ready,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output calf_pkg::t_hw_ctl  o_hw,
    output logic [AW-1:0]      o_wr_addr,
    output calf_pkg::t_mul_ctl o_mul,
    output logic [KW-1:0]      o_mul_k,
    output calf_pkg::t_acc_ctl o_acc,
    output logic               o_x_load,
    output logic               o_out_load,
    output logic               o_cur_wr,
    output logic [KW-1:0]      o_k
);

    import calf_pkg::*;

    localparam int PW = (PASSES > 1) ? $clog2(PASSES) : 1;

    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [PW-1:0] r_pass, n_pass;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_s1_vld;
    t_src          r_s1_src;
    logic [KW-1:0] r_s1_k;
    logic [AW-1:0] r_s1_addr;
    logic          issue;
    t_src          issue_src;
    logic          last_pass;

    assign last_pass = (r_pass == PW'(PASSES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_op) inside
                        OP_FILTER:       n_state = ST_F_RUN;
                        OP_BLEND:        n_state = ST_B_KEEP;
                        OP_COEF, OP_NONE: n_state = ST_IDLE;
                        default:         n_state = ST_IDLE;
                    endcase
                end
            end
            ST_F_RUN: begin
                if (r_k == '0) n_state = ST_F_DRAIN1;
            end
            ST_F_DRAIN1: n_state = ST_F_DRAIN2;
            ST_F_DRAIN2: n_state = ST_F_FIN;
            ST_F_FIN:    n_state = last_pass ? ST_F_OUT : ST_F_RUN;
            ST_F_OUT: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            ST_B_KEEP:   n_state = ST_B_GIVE;
            ST_B_GIVE:   n_state = ST_B_WAIT1;
            ST_B_WAIT1:  n_state = ST_B_WAIT2;
            ST_B_WAIT2:  n_state = ST_B_WB;
            ST_B_WB:     n_state = (r_k == KW'(ORDER - 1)) ? ST_IDLE : ST_B_KEEP;
            default:     n_state = ST_IDLE;
        endcase
    end

    // counters
    always_comb begin
        n_k    = r_k;
        n_pass = r_pass;
        n_base = r_base;
        n_clr  = r_clr;
        unique case (r_state)
            ST_CLEAR: n_clr = r_clr + AW'(1);
            ST_IDLE: begin
                n_k    = (i_op == OP_BLEND) ? '0 : KW'(ORDER - 1);
                n_pass = '0;
                n_base = '0;
            end
            ST_F_RUN: begin
                if (r_k != '0) n_k = r_k - KW'(1);
            end
            ST_F_FIN: begin
                n_k    = KW'(ORDER - 1);
                n_pass = r_pass + PW'(1);
                n_base = r_base + AW'(ORDER);
            end
            ST_B_WB: n_k = r_k + KW'(1);
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        issue      = 1'b0;
        issue_src  = SRC_HIST;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_base + AW'(r_k);
        o_hw.en    = 1'b0;
        o_hw.sel   = HW_ZERO;
        o_wr_addr  = r_clr;
        o_acc.load = 1'b0;
        o_acc.blend = 1'b0;
        o_x_load   = 1'b0;
        o_out_load = 1'b0;
        o_cur_wr   = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_hw.en = 1'b1;
            ST_F_RUN: begin
                issue      = 1'b1;
                o_rd_en    = 1'b1;
                o_acc.load = (r_k == KW'(ORDER - 1));
            end
            ST_F_FIN: begin
                o_hw.en   = 1'b1;
                o_hw.sel  = HW_Y;
                o_wr_addr = r_base;
                o_x_load  = 1'b1;
            end
            ST_F_OUT: o_out_load = i_out_free;
            ST_B_KEEP: begin
                issue       = 1'b1;
                issue_src   = SRC_KEEP;
                o_acc.load  = 1'b1;
                o_acc.blend = 1'b1;
            end
            ST_B_GIVE: begin
                issue     = 1'b1;
                issue_src = SRC_GIVE;
            end
            ST_B_WB: o_cur_wr = 1'b1;
            default: ;
        endcase
        // tap k moves one place down the history as it passes the multiplier
        if (r_s1_vld && (r_s1_src == SRC_HIST) && (r_s1_k != KW'(ORDER - 1))) begin
            o_hw.en   = 1'b1;
            o_hw.sel  = HW_SHIFT;
            o_wr_addr = r_s1_addr + AW'(1);
        end
        o_mul.mul_en = r_s1_vld;
        o_mul.sub    = (r_s1_src == SRC_HIST);
        o_mul.src    = r_s1_src;
        o_mul_k      = r_s1_k;
        o_k          = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_k      <= '0;
            r_pass   <= '0;
            r_base   <= '0;
            r_clr    <= '0;
            r_s1_vld <= 1'b0;
            r_s1_src <= SRC_HIST;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_pass   <= n_pass;
            r_base   <= n_base;
            r_clr    <= n_clr;
            r_s1_vld <= issue;
            r_s1_src <= issue_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k    <= r_k;
        r_s1_addr <= o_rd_addr;
    end

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hw.en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("history read and write hit the same entry");

    a_fin_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_FIN) |-> (!r_s1_vld && !o_mul.mul_en))
        else $error("pass finished while a tap was still in flight");

endmodule

>>> hdl/cascaded_all_pole_lpc_filter.sv
// top level: cascaded all-pole lpc synthesis filter with coefficient blending
// depends on calf_pkg, calf_ram, calf_mac and calf_ctrl
//
//   channel   direction  handshake                  payload
//   input     in         i_valid / o_ready          i_op, i_coef_index, i_coef_value, i_sample
//   result    out        o_valid / i_ready          o_filtered_sample
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_blend_decay
//
// each filter pass runs one multiply-accumulate per tap on the shared 24x32 mac, then a
// pipeline tail through the drain and finish states; a blend steps each coefficient
// through keep, give, wait and write-back states; coefficient writes and unused ops leave
// the sequencer idle; after reset the history ram is swept to zero, o_ready low
// one result register decouples the output; the sequencer waits only if full and i_ready low
`timescale 1ns / 1ps

module cascaded_all_pole_lpc_filter #(
    parameter int ORDER  = 16,
    parameter int PASSES = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_coef_index,
    input  logic signed [23:0] i_coef_value,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_filtered_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_blend_decay
);

    import calf_pkg::*;

    localparam int DEPTH = PASSES * ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (ORDER > 1) ? $clog2(ORDER) : 1;

    logic               accept;
    t_op                op;
    logic               out_free;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;
    t_hw_ctl            hw;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    t_mul_ctl           mul;
    logic [KW-1:0]      mul_k;
    t_acc_ctl           acc_ctl;
    logic               x_load;
    logic               out_load;
    logic               cur_wr;
    logic [KW-1:0]      k;
    logic signed [23:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] acc;
    logic signed [31:0] y_sat;

    logic [15:0]        r_decay;
    logic signed [23:0] r_cur [ORDER];
    logic signed [23:0] r_tgt [ORDER];
    logic signed [31:0] r_x;
    logic               r_out_vld;
    logic signed [31:0] r_out;

    assign op       = t_op'(i_op);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign y_sat    = round_sat32(acc);

    calf_ctrl #(
        .ORDER  (ORDER),
        .PASSES (PASSES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (op),
        .i_out_free (out_free),
        .o_ready    (o_ready),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_hw       (hw),
        .o_wr_addr  (wr_addr),
        .o_mul      (mul),
        .o_mul_k    (mul_k),
        .o_acc      (acc_ctl),
        .o_x_load   (x_load),
        .o_out_load (out_load),
        .o_cur_wr   (cur_wr),
        .o_k        (k)
    );

    always_comb begin
        case (hw.sel)
            HW_SHIFT: wr_data = rd_data;
            HW_Y:     wr_data = y_sat;
            default:  wr_data = '0;
        endcase
    end

    calf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hw.en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_a = (mul.src == SRC_GIVE) ? r_tgt[mul_k] : r_cur[mul_k];
        case (mul.src)
            SRC_HIST: mul_b = $signed(rd_data);
            SRC_KEEP: mul_b = $signed({16'h0000, r_decay});
            SRC_GIVE: mul_b = $signed({15'h0000, blend_give(r_decay)});
            default:  mul_b = '0;
        endcase
    end

    calf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mul   (mul),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_acc   (acc_ctl),
        .i_x     (r_x),
        .o_acc   (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
        end else if (i_cfg_valid) begin
            r_decay <= i_cfg_blend_decay;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            if (accept && (op == OP_COEF) && (int'(i_coef_index) < ORDER)) begin
                r_tgt[KW'(i_coef_index)] <= i_coef_value;
            end
            // blend result fits 24 bits, so the low 40 accumulator bits carry it
            if (cur_wr) begin
                r_cur[k] <= acc[39:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= {{16{i_sample[15]}}, i_sample};
        end else if (x_load) begin
            r_x <= y_sat;
        end
        if (out_load) begin
            r_out <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_filtered_sample = r_out;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_vld || i_ready))
        else $error("result register overwritten before transfer");

endmodule
